// File: hdl/ooit_pkg.sv
// Shared types and constants for the oldest outstanding ID tracker.
package ooit_pkg;

   localparam int NUM_IDS = 256;
   localparam int IDX_W   = $clog2(NUM_IDS);
   localparam int CNT_W   = $clog2(NUM_IDS + 1);
   localparam int ID_W    = 9;

   typedef enum logic [1:0] {
      REQ_CALL     = 2'd0,
      REQ_COMPLETE = 2'd1,
      REQ_RECALL   = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALL,
      ST_COMPLETE,
      ST_SCAN_RD,
      ST_SCAN_CHK
   } state_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic             data;
   } bmp_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } bmp_rd_type;

endpackage

// File: hdl/ooit_bitmap.sv
// Outstanding bitmap: one bit per ID, one write port and one registered read port.
module ooit_bitmap
   import ooit_pkg::*;
(
   input  logic       clock,
   input  bmp_wr_type wr,
   input  bmp_rd_type rd,
   output logic       rd_data
);

   logic mem [NUM_IDS];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/oldest_outstanding_id_tracker.sv
// Top level of the oldest outstanding ID tracker.
// An item is taken when start is high and busy is low; busy then stays high
// until the item is finished. A call or a complete goes through its own state,
// ST_CALL or ST_COMPLETE, and then returns to idle. A recall alternates between
// ST_SCAN_RD and ST_SCAN_CHK, stepping over every done ID, until it finds an
// outstanding ID or the scan pointer reaches the call count; the scan pointer
// only moves forward, so over the life of the block it steps over at most
// NUM_IDS entries. The scan reads the bitmap memory one entry per step through
// its single registered read port. A recall that finds an ID raises rsp_valid
// for one cycle, the first cycle with busy low again; the receiver cannot
// stall it. Bitmap entries at or above the call count are never read, so the
// memory needs no clearing pass after reset.
module oldest_outstanding_id_tracker
   import ooit_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [1:0]      req_type,
   input  logic [ID_W-1:0] req_person_id,
   output logic            rsp_valid,
   output logic [ID_W-1:0] rsp_recalled_id
);

   state_type        state_ff, state_in;
   logic [ID_W-1:0]  pid_ff, pid_in;
   logic [CNT_W-1:0] nu_ff, nu_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;

   bmp_wr_type       bmp_wr;
   bmp_rd_type       bmp_rd;
   logic             bmp_rd_data;
   logic [ID_W-1:0]  slot;
   logic             accept;
   logic             call_ok;
   logic             complete_ok;
   logic             scan_live;

   ooit_bitmap u_bitmap (
      .clock   (clock),
      .wr      (bmp_wr),
      .rd      (bmp_rd),
      .rd_data (bmp_rd_data)
   );

   assign accept      = start && (state_ff == ST_IDLE);
   assign slot        = pid_ff - ID_W'(1);
   assign call_ok     = (nu_ff < CNT_W'(NUM_IDS));
   // ID 0 wraps to a slot above the call count and drops out here too
   assign complete_ok = (ID_W'(slot) < ID_W'(nu_ff));
   assign scan_live   = (head_ff < nu_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_CALL:     state_in = ST_CALL;
                  REQ_COMPLETE: state_in = ST_COMPLETE;
                  REQ_RECALL:   state_in = ST_SCAN_RD;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_CALL:     state_in = ST_IDLE;
         ST_COMPLETE: state_in = ST_IDLE;
         ST_SCAN_RD:  state_in = scan_live ? ST_SCAN_CHK : ST_IDLE;
         ST_SCAN_CHK: state_in = bmp_rd_data ? ST_IDLE : ST_SCAN_RD;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pid_in       = pid_ff;
      nu_in        = nu_ff;
      head_in      = head_ff;
      rsp_valid_in = 1'b0;
      rsp_id_in    = rsp_id_ff;
      bmp_wr       = '0;
      bmp_rd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pid_in = req_person_id;
            end
         end
         ST_CALL: begin
            if (call_ok) begin
               bmp_wr.en   = 1'b1;
               bmp_wr.addr = nu_ff[IDX_W-1:0];
               bmp_wr.data = 1'b1;
               nu_in       = nu_ff + CNT_W'(1);
            end
         end
         ST_COMPLETE: begin
            if (complete_ok) begin
               bmp_wr.en   = 1'b1;
               bmp_wr.addr = slot[IDX_W-1:0];
               bmp_wr.data = 1'b0;
            end
         end
         ST_SCAN_RD: begin
            bmp_rd.en   = scan_live;
            bmp_rd.addr = head_ff[IDX_W-1:0];
         end
         ST_SCAN_CHK: begin
            if (bmp_rd_data) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = ID_W'(head_ff) + ID_W'(1);
            end else begin
               // entry is done for good: advance past it
               head_in = head_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nu_ff        <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nu_ff        <= nu_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff    <= pid_in;
      rsp_id_ff <= rsp_id_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_recalled_id = rsp_id_ff;

   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_SCAN_CHK))
      else $error("result strobe without a scan hit");

   a_head_below_count: assert property (@(posedge clock) disable iff (reset)
      head_ff <= nu_ff)
      else $error("scan pointer passed the call count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      nu_ff <= CNT_W'(NUM_IDS))
      else $error("call count above ID range");

   a_rsp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_recalled_id != '0) && (ID_W'(rsp_recalled_id) <= ID_W'(nu_ff)))
      else $error("recalled ID outside the called range");

   a_head_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff != ST_SCAN_CHK) |-> $stable(head_ff))
      else $error("scan pointer moved outside a scan step");

endmodule
